>>> hdl/jslec_pkg.sv
// Shared types, constants and arithmetic helpers for the soft joint limit effort clamp.
`default_nettype none

package jslec_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned GAIN_W  = 31;
    localparam int unsigned DIFF_W  = 33;
    localparam int unsigned PROD_W  = 64;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned IN_W    = 96;
    localparam int unsigned NSTAGE  = 9;

    localparam logic signed [DATA_W-1:0] VEL_LIMIT_RST = -32'sd65536;

    typedef enum logic [IDX_W-1:0] {
        CFG_POS_UPPER   = 3'd0,
        CFG_POS_LOWER   = 3'd1,
        CFG_VEL_LIMIT   = 3'd2,
        CFG_POS_GAIN    = 3'd3,
        CFG_VEL_GAIN    = 3'd4,
        CFG_EFF_LIMIT   = 3'd5,
        CFG_SAFETY_EN   = 3'd6,
        CFG_CONTINUOUS  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_upper_bound;
        logic signed [DATA_W-1:0] pos_lower_bound;
        logic signed [DATA_W-1:0] velocity_limit;
        logic        [GAIN_W-1:0] position_gain;
        logic        [GAIN_W-1:0] velocity_gain;
        logic        [GAIN_W-1:0] effort_limit;
        logic                     safety_enable;
        logic                     unbounded_joint;
    } t_cfg;

    // -(p) scaled by 2^-16 with floor, saturated to 32 bits
    function automatic logic signed [DATA_W-1:0] neg_q16_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] n;
        logic signed [PROD_W-17:0] q;
        logic signed [DATA_W-1:0] r;
        n = -p;
        q = n[PROD_W-1:16];
        if (q[PROD_W-17:DATA_W-1] == '0 || q[PROD_W-17:DATA_W-1] == '1) begin
            r = q[DATA_W-1:0];
        end else if (q[PROD_W-17]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [DIFF_W-1:0] min33(input logic signed [DIFF_W-1:0] a,
                                                      input logic signed [DIFF_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [DIFF_W-1:0] max33(input logic signed [DIFF_W-1:0] a,
                                                      input logic signed [DIFF_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

>>> hdl/joint_soft_limit_effort_clamp.sv
// Top level: nine-stage pipelined soft joint limit effort clamp with config registers.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata {requested_effort, velocity, position}, tuser calibrated
//  m_axis    out        tdata limited_effort
//  cfg       in         i_cfg_we / i_cfg_idx / i_cfg_data, write only
//
//  Nine register stages, one transaction per cycle sustained while m_axis_tready is high.
//  Depth is set by the two 31x33 multiply passes and their clamp chains.
//  Each stage stalls only when it is full and the next one is stalled; bubbles fill.
//  Synchronous active-low reset clears valid bits and config registers, except velocity_limit, which resets to -65536.
`default_nettype none

module joint_soft_limit_effort_clamp (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,   // position[31:0], velocity[63:32], requested_effort[95:64]
    input  wire logic [0:0]  s_axis_tuser,   // calibrated[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // limited_effort[31:0]
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    localparam int unsigned DW = jslec_pkg::DATA_W;
    localparam int unsigned XW = jslec_pkg::DIFF_W;
    localparam int unsigned PW = jslec_pkg::PROD_W;
    localparam int unsigned NS = jslec_pkg::NSTAGE;

    jslec_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_upper_bound <= '0;
            r_cfg.pos_lower_bound <= '0;
            r_cfg.velocity_limit  <= jslec_pkg::VEL_LIMIT_RST;
            r_cfg.position_gain   <= '0;
            r_cfg.velocity_gain   <= '0;
            r_cfg.effort_limit    <= '0;
            r_cfg.safety_enable   <= 1'b0;
            r_cfg.unbounded_joint <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (jslec_pkg::t_cfg_idx'(i_cfg_idx))
                jslec_pkg::CFG_POS_UPPER:  r_cfg.pos_upper_bound  <= i_cfg_data;
                jslec_pkg::CFG_POS_LOWER:  r_cfg.pos_lower_bound  <= i_cfg_data;
                jslec_pkg::CFG_VEL_LIMIT:  r_cfg.velocity_limit   <= i_cfg_data;
                jslec_pkg::CFG_POS_GAIN:   r_cfg.position_gain    <= i_cfg_data[30:0];
                jslec_pkg::CFG_VEL_GAIN:   r_cfg.velocity_gain    <= i_cfg_data[30:0];
                jslec_pkg::CFG_EFF_LIMIT:  r_cfg.effort_limit     <= i_cfg_data[30:0];
                jslec_pkg::CFG_SAFETY_EN:  r_cfg.safety_enable    <= i_cfg_data[0];
                jslec_pkg::CFG_CONTINUOUS: r_cfg.unbounded_joint  <= i_cfg_data[0];
            endcase
        end
    end

    // stage valids and per-stage load enables
    logic [NS:1]   r_v;
    logic [NS:1]   w_en;
    logic [NS-1:0] w_vin;

    always_comb begin
        w_en[NS] = !r_v[NS] || m_axis_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
        w_vin = {r_v[NS-1:1], s_axis_tvalid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= w_vin[k-1];
                end
            end
        end
    end

    assign s_axis_tready = w_en[1];

    // shared config views
    logic signed [XW-1:0] w_vl;
    logic signed [XW-1:0] w_nvl;
    logic signed [DW-1:0] w_el;
    logic signed [DW-1:0] w_nel;
    logic signed [DW-1:0] w_pgain;
    logic signed [DW-1:0] w_vgain;

    assign w_vl    = XW'(r_cfg.velocity_limit);
    assign w_nvl   = -w_vl;
    assign w_el    = {1'b0, r_cfg.effort_limit};
    assign w_nel   = -w_el;
    assign w_pgain = {1'b0, r_cfg.position_gain};
    assign w_vgain = {1'b0, r_cfg.velocity_gain};

    logic signed [DW-1:0] w_pos, w_vel, w_req;
    assign w_pos = s_axis_tdata[31:0];
    assign w_vel = s_axis_tdata[63:32];
    assign w_req = s_axis_tdata[95:64];

    // payload stages
    logic signed [DW-1:0] r1_vel, r2_vel, r3_vel, r4_vel;
    logic signed [DW-1:0] r1_req, r2_req, r3_req, r4_req, r5_req, r6_req, r7_req, r8_req;
    logic                 r1_cal, r2_cal, r3_cal;
    logic signed [XW-1:0] r1_dup, r1_dlo;
    logic signed [PW-1:0] r2_pup, r2_plo;
    logic signed [DW-1:0] r3_qup, r3_qlo;
    logic signed [XW-1:0] r4_vhi, r4_vlo;
    logic signed [XW-1:0] r5_dhi, r5_dlo;
    logic signed [PW-1:0] r6_phi, r6_plo;
    logic signed [DW-1:0] r7_qhi, r7_qlo;
    logic signed [DW-1:0] r8_ehi, r8_elo;
    logic signed [DW-1:0] r9_res;

    logic signed [PW:0]   w_pup, w_plo, w_phi, w_plo2;
    logic signed [XW-1:0] w_vhi, w_vlo;
    logic signed [DW-1:0] w_ehi, w_elo, w_res;

    assign w_pup  = w_pgain * r1_dup;
    assign w_plo  = w_pgain * r1_dlo;
    assign w_phi  = w_vgain * r5_dhi;
    assign w_plo2 = w_vgain * r5_dlo;

    always_comb begin
        if (r3_cal && !r_cfg.unbounded_joint) begin
            w_vhi = jslec_pkg::max33(w_nvl, jslec_pkg::min33(w_vl, XW'(r3_qup)));
            w_vlo = jslec_pkg::min33(w_vl, jslec_pkg::max33(w_nvl, XW'(r3_qlo)));
        end else begin
            w_vhi = w_vl;
            w_vlo = w_nvl;
        end
    end

    always_comb begin
        if (!r_cfg.velocity_limit[DW-1]) begin
            w_ehi = (r7_qhi < w_el) ? r7_qhi : w_el;
            w_ehi = (w_ehi > w_nel) ? w_ehi : w_nel;
            w_elo = (r7_qlo > w_nel) ? r7_qlo : w_nel;
            w_elo = (w_elo < w_el) ? w_elo : w_el;
        end else begin
            w_ehi = w_el;
            w_elo = w_nel;
        end
    end

    always_comb begin
        w_res = (r8_req > r8_elo) ? r8_req : r8_elo;
        w_res = (w_res < r8_ehi) ? w_res : r8_ehi;
        if (!r_cfg.safety_enable) begin
            w_res = r8_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_vel <= w_vel;
            r1_req <= w_req;
            r1_cal <= s_axis_tuser[0];
            r1_dup <= XW'(w_pos) - XW'(r_cfg.pos_upper_bound);
            r1_dlo <= XW'(w_pos) - XW'(r_cfg.pos_lower_bound);
        end
        if (w_en[2]) begin
            r2_vel <= r1_vel;
            r2_req <= r1_req;
            r2_cal <= r1_cal;
            r2_pup <= w_pup[PW-1:0];
            r2_plo <= w_plo[PW-1:0];
        end
        if (w_en[3]) begin
            r3_vel <= r2_vel;
            r3_req <= r2_req;
            r3_cal <= r2_cal;
            r3_qup <= jslec_pkg::neg_q16_sat(r2_pup);
            r3_qlo <= jslec_pkg::neg_q16_sat(r2_plo);
        end
        if (w_en[4]) begin
            r4_vel <= r3_vel;
            r4_req <= r3_req;
            r4_vhi <= w_vhi;
            r4_vlo <= w_vlo;
        end
        if (w_en[5]) begin
            r5_req <= r4_req;
            r5_dhi <= XW'(r4_vel) - r4_vhi;
            r5_dlo <= XW'(r4_vel) - r4_vlo;
        end
        if (w_en[6]) begin
            r6_req <= r5_req;
            r6_phi <= w_phi[PW-1:0];
            r6_plo <= w_plo2[PW-1:0];
        end
        if (w_en[7]) begin
            r7_req <= r6_req;
            r7_qhi <= jslec_pkg::neg_q16_sat(r6_phi);
            r7_qlo <= jslec_pkg::neg_q16_sat(r6_plo);
        end
        if (w_en[8]) begin
            r8_req <= r7_req;
            r8_ehi <= w_ehi;
            r8_elo <= w_elo;
        end
        if (w_en[9]) begin
            r9_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_v[NS];
    assign m_axis_tdata  = r9_res;

`ifndef ASSERT_OFF
    a_rst_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v == '1) && !m_axis_tready)
        else $error("input stalled with a bubble in the pipeline");
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_v[1])
        else $error("accepted transaction lost at first stage");
`endif

endmodule

`default_nettype wire
